>>> hdl/srec_pkg.sv
// Shared types, constants and helper functions for the S19 record stream encoder.
package srec_pkg;

  localparam int unsigned RECORD_DATA_BYTES_DEF = 16;
  localparam int unsigned HDR_MAX               = 16;
  localparam int unsigned LEN_W                 = 5;
  localparam int unsigned IDX_W                 = 4;
  localparam int unsigned ADDR_W                = 16;
  localparam int unsigned TEXT_W                = 64;
  localparam int unsigned CFG_IDX_W             = 2;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_DATA  = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_HDR_HIGH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HDR_LOW    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HDR_LENGTH = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_ADDR = 2'd3;

  localparam logic [7:0] CHAR_NL = 8'h0A;
  localparam logic [7:0] CHAR_S  = 8'h53;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_NL,
    ST_S,
    ST_TYPE,
    ST_CNT_H,
    ST_CNT_L,
    ST_AH_H,
    ST_AH_L,
    ST_AL_H,
    ST_AL_L,
    ST_DAT_H,
    ST_DAT_L,
    ST_CHK_H,
    ST_CHK_L
  } state_e;

  typedef enum logic [1:0] {
    REC_S0,
    REC_S1,
    REC_S5,
    REC_S9
  } rec_e;

  typedef enum logic [2:0] {
    FLD_NL,
    FLD_S,
    FLD_TYPE,
    FLD_CNT,
    FLD_ADH,
    FLD_ADL,
    FLD_DAT,
    FLD_CHK
  } field_e;

  typedef struct packed {
    logic   accept;
    logic   rec_start;
    rec_e   rec;
    logic   emit;
    field_e field;
    logic   lo;
    logic   last;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic nonempty;
    logic len_zero;
    logic idx_last;
    logic out_free;
  } status_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = 8'h30 + {4'd0, nib};
    end else begin
      c = 8'h37 + {4'd0, nib};
    end
    return c;
  endfunction

  function automatic logic [7:0] type_char(input rec_e rec);
    logic [7:0] c;
    unique case (rec)
      REC_S0:  c = 8'h30;
      REC_S1:  c = 8'h31;
      REC_S5:  c = 8'h35;
      REC_S9:  c = 8'h39;
      default: c = 8'h30;
    endcase
    return c;
  endfunction

endpackage

>>> hdl/srec_ctrl.sv
// Controller state machine that sequences the characters of each record.
module srec_ctrl import srec_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic [1:0] op_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;
  rec_e   rec_q, rec_d;
  logic   end_q, end_d;
  logic   accept;
  logic   more;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign more       = ((rec_q == REC_S1) && end_q) || (rec_q == REC_S5);

  always_comb begin
    state_d = state_q;
    rec_d   = rec_q;
    end_d   = end_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          priority if (op_i == OP_START) begin
            state_d = ST_START;
            rec_d   = REC_S0;
            end_d   = 1'b0;
          end else if (op_i == OP_DATA) begin
            if (status_i.full) begin
              state_d = ST_START;
              rec_d   = REC_S1;
              end_d   = 1'b0;
            end
          end else if (op_i == OP_END) begin
            state_d = ST_START;
            end_d   = 1'b1;
            rec_d   = status_i.nonempty ? REC_S1 : REC_S5;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_START: state_d = (rec_q == REC_S0) ? ST_S : ST_NL;
      ST_NL:    if (status_i.out_free) state_d = ST_S;
      ST_S:     if (status_i.out_free) state_d = ST_TYPE;
      ST_TYPE:  if (status_i.out_free) state_d = ST_CNT_H;
      ST_CNT_H: if (status_i.out_free) state_d = ST_CNT_L;
      ST_CNT_L: if (status_i.out_free) state_d = ST_AH_H;
      ST_AH_H:  if (status_i.out_free) state_d = ST_AH_L;
      ST_AH_L:  if (status_i.out_free) state_d = ST_AL_H;
      ST_AL_H:  if (status_i.out_free) state_d = ST_AL_L;
      ST_AL_L: begin
        if (status_i.out_free) begin
          state_d = status_i.len_zero ? ST_CHK_H : ST_DAT_H;
        end
      end
      ST_DAT_H: if (status_i.out_free) state_d = ST_DAT_L;
      ST_DAT_L: begin
        if (status_i.out_free) begin
          state_d = status_i.idx_last ? ST_CHK_H : ST_DAT_H;
        end
      end
      ST_CHK_H: if (status_i.out_free) state_d = ST_CHK_L;
      ST_CHK_L: begin
        if (status_i.out_free) begin
          if (more) begin
            state_d = ST_START;
            rec_d   = (rec_q == REC_S1) ? REC_S5 : REC_S9;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.accept    = accept;
    cmd_o.rec       = rec_q;
    cmd_o.rec_start = (state_q == ST_START);
    cmd_o.field     = FLD_NL;
    unique case (state_q)
      ST_IDLE, ST_START: cmd_o.emit = 1'b0;
      ST_NL: begin
        cmd_o.emit  = status_i.out_free;
        cmd_o.field = FLD_NL;
      end
      ST_S: begin
        cmd_o.emit  = status_i.out_free;
        cmd_o.field = FLD_S;
      end
      ST_TYPE: begin
        cmd_o.emit  = status_i.out_free;
        cmd_o.field = FLD_TYPE;
      end
      ST_CNT_H, ST_CNT_L: begin
        cmd_o.emit  = status_i.out_free;
        cmd_o.field = FLD_CNT;
        cmd_o.lo    = (state_q == ST_CNT_L);
      end
      ST_AH_H, ST_AH_L: begin
        cmd_o.emit  = status_i.out_free;
        cmd_o.field = FLD_ADH;
        cmd_o.lo    = (state_q == ST_AH_L);
      end
      ST_AL_H, ST_AL_L: begin
        cmd_o.emit  = status_i.out_free;
        cmd_o.field = FLD_ADL;
        cmd_o.lo    = (state_q == ST_AL_L);
      end
      ST_DAT_H, ST_DAT_L: begin
        cmd_o.emit  = status_i.out_free;
        cmd_o.field = FLD_DAT;
        cmd_o.lo    = (state_q == ST_DAT_L);
      end
      ST_CHK_H, ST_CHK_L: begin
        cmd_o.emit  = status_i.out_free;
        cmd_o.field = FLD_CHK;
        cmd_o.lo    = (state_q == ST_CHK_L);
        cmd_o.last  = (state_q == ST_CHK_L) && !more;
      end
      default: cmd_o.emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rec_q   <= REC_S0;
      end_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      rec_q   <= rec_d;
      end_q   <= end_d;
    end
  end

endmodule

>>> hdl/srec_dp.sv
// Datapath: configuration, byte buffer, record state, checksum and output register.
module srec_dp import srec_pkg::*; #(
  parameter int unsigned RECORD_DATA_BYTES = RECORD_DATA_BYTES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [TEXT_W-1:0]    cfg_wdata_i,
  input  logic [1:0]           op_i,
  input  logic [7:0]           data_byte_i,
  input  cmd_t                 cmd_i,
  output status_t              status_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           character_o,
  output logic                 last_of_run_o
);

  localparam int unsigned FW = $clog2(RECORD_DATA_BYTES + 1);
  localparam int unsigned BW = (RECORD_DATA_BYTES > 1) ? $clog2(RECORD_DATA_BYTES) : 1;

  logic [TEXT_W-1:0] hdr_high_q, hdr_low_q;
  logic [LEN_W-1:0]  hdr_len_q;
  logic [ADDR_W-1:0] start_addr_q;

  logic [7:0]        buf_q [RECORD_DATA_BYTES];
  logic [FW-1:0]     fill_q, fill_d, fill_inc;
  logic [ADDR_W-1:0] rec_addr_q, rec_addr_d;
  logic [ADDR_W-1:0] rec_cnt_q, rec_cnt_d;

  logic [LEN_W-1:0]  len_q, len_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [7:0]        sum_q, sum_d;

  logic              out_valid_q;
  logic [7:0]        char_q;
  logic              last_q;

  logic [LEN_W-1:0]  hdr_len_clamped;
  logic [7:0]        hdr_byte, data_src, field_byte;
  logic [7:0]        char_d;
  logic [2*TEXT_W-1:0] hdr_text;
  logic              open_stream;

  assign fill_inc        = fill_q + 1'b1;
  assign hdr_len_clamped = (hdr_len_q > LEN_W'(HDR_MAX)) ? LEN_W'(HDR_MAX) : hdr_len_q;
  assign hdr_text        = {hdr_high_q, hdr_low_q};
  assign hdr_byte        = hdr_text[2*TEXT_W-1-8*idx_q -: 8];
  assign data_src        = (cmd_i.rec == REC_S0) ? hdr_byte : buf_q[idx_q[BW-1:0]];

  assign status_o.full     = (fill_inc == FW'(RECORD_DATA_BYTES));
  assign status_o.nonempty = (fill_q != '0);
  assign status_o.len_zero = (len_q == '0);
  assign status_o.idx_last = (({1'b0, idx_q} + LEN_W'(1)) == len_q);
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign open_stream = (cmd_i.accept && (op_i == OP_START))
                    || (cmd_i.rec_start && (cmd_i.rec == REC_S9));

  always_comb begin
    unique case (cmd_i.field)
      FLD_CNT: field_byte = {3'd0, len_q} + 8'd3;
      FLD_ADH: field_byte = addr_q[15:8];
      FLD_ADL: field_byte = addr_q[7:0];
      FLD_DAT: field_byte = data_src;
      FLD_CHK: field_byte = ~sum_q;
      default: field_byte = 8'd0;
    endcase
  end

  always_comb begin
    unique case (cmd_i.field)
      FLD_NL:   char_d = CHAR_NL;
      FLD_S:    char_d = CHAR_S;
      FLD_TYPE: char_d = type_char(cmd_i.rec);
      default:  char_d = hex_char(cmd_i.lo ? field_byte[3:0] : field_byte[7:4]);
    endcase
  end

  always_comb begin
    fill_d     = fill_q;
    rec_addr_d = rec_addr_q;
    rec_cnt_d  = rec_cnt_q;
    len_d      = len_q;
    addr_d     = addr_q;
    idx_d      = idx_q;
    sum_d      = sum_q;
    if (cmd_i.accept && (op_i == OP_DATA)) begin
      fill_d = fill_inc;
    end
    if (cmd_i.rec_start) begin
      idx_d = '0;
      sum_d = '0;
      unique case (cmd_i.rec)
        REC_S0: begin
          len_d  = hdr_len_clamped;
          addr_d = '0;
        end
        REC_S1: begin
          len_d      = LEN_W'(fill_q);
          addr_d     = rec_addr_q;
          rec_addr_d = rec_addr_q + ADDR_W'(fill_q);
          rec_cnt_d  = rec_cnt_q + 1'b1;
          fill_d     = '0;
        end
        REC_S5: begin
          len_d  = '0;
          addr_d = rec_cnt_q;
        end
        REC_S9: begin
          len_d  = '0;
          addr_d = '0;
        end
        default: len_d = '0;
      endcase
    end
    if (open_stream) begin
      fill_d     = '0;
      rec_cnt_d  = '0;
      rec_addr_d = start_addr_q;
    end
    if (cmd_i.emit && cmd_i.lo) begin
      sum_d = sum_q + field_byte;
      if (cmd_i.field == FLD_DAT) begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_high_q   <= '0;
      hdr_low_q    <= '0;
      hdr_len_q    <= '0;
      start_addr_q <= '0;
      fill_q       <= '0;
      rec_addr_q   <= '0;
      rec_cnt_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_HDR_HIGH:   hdr_high_q   <= cfg_wdata_i;
          CFG_HDR_LOW:    hdr_low_q    <= cfg_wdata_i;
          CFG_HDR_LENGTH: hdr_len_q    <= cfg_wdata_i[LEN_W-1:0];
          CFG_START_ADDR: start_addr_q <= cfg_wdata_i[ADDR_W-1:0];
          default:        hdr_len_q    <= hdr_len_q;
        endcase
      end
      fill_q     <= fill_d;
      rec_addr_q <= rec_addr_d;
      rec_cnt_q  <= rec_cnt_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    len_q  <= len_d;
    addr_q <= addr_d;
    idx_q  <= idx_d;
    sum_q  <= sum_d;
    if (cmd_i.accept && (op_i == OP_DATA)) begin
      buf_q[fill_q[BW-1:0]] <= data_byte_i;
    end
    if (cmd_i.emit) begin
      char_q <= char_d;
      last_q <= cmd_i.last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign character_o   = char_q;
  assign last_of_run_o = last_q;

endmodule

>>> hdl/s_record_stream_encoder_top.sv
// Top level of the S19 record stream encoder: controller and datapath.
//
// Channel  Direction  Handshake             Content
// in       input      in_valid/in_ready     op, data_byte
// out      output     out_valid/out_ready   character, last_of_run (one per beat)
// cfg      input      cfg_we                cfg_index, cfg_wdata
//
// One input beat is taken at a time, only while the sequencer is idle.
// A data beat that does not complete a record leaves the sequencer idle; a beat that causes
// output passes through a set-up state per record and one state per character,
// since the output register holds one character.
// Output stalls hold the sequencer; the last character may wait while a new beat is taken.
// Reset clears configuration, counters and address; the byte buffer is not cleared.
module s_record_stream_encoder_top import srec_pkg::*; #(
  parameter int unsigned RECORD_DATA_BYTES = RECORD_DATA_BYTES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [TEXT_W-1:0]    cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           op_i,
  input  logic [7:0]           data_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           character_o,
  output logic                 last_of_run_o
);

  cmd_t    cmd;
  status_t status;

  srec_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (op_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  srec_dp #(
    .RECORD_DATA_BYTES (RECORD_DATA_BYTES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .op_i          (op_i),
    .data_byte_i   (data_byte_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .character_o   (character_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

>>> test/srec_check.sv
// Checker for the S19 encoder: predicts the character beats of each input beat and compares them.
module srec_check import srec_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [TEXT_W-1:0]    cfg_wdata_i,
  input  logic                 in_valid_i,
  input  logic                 in_ready_o,
  input  logic [1:0]           op_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  logic [7:0]           character_o,
  input  logic                 last_of_run_o,
  output int                   mismatch_count,
  output int                   chars_pending
);

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } srec_beat_t;

  srec_beat_t expected_beats[$];

  logic [TEXT_W-1:0] hdr_hi;
  logic [TEXT_W-1:0] hdr_lo;
  logic [LEN_W-1:0]  hdr_len;
  logic [ADDR_W-1:0] load_addr;

  logic [7:0]        held_bytes[RECORD_DATA_BYTES_DEF];
  logic [7:0]        rec_bytes[HDR_MAX];
  int unsigned       held_count;
  logic [ADDR_W-1:0] rec_addr;
  logic [15:0]       s1_count;

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    return (nib > 4'd9) ? 8'h41 + {4'd0, nib} - 8'd10 : 8'h30 + {4'd0, nib};
  endfunction

  task automatic push_char(input logic [7:0] c);
    expected_beats.push_back('{ch: c, last: 1'b0});
  endtask

  task automatic push_hex(input logic [7:0] v);
    push_char(hex_digit(v[7:4]));
    push_char(hex_digit(v[3:0]));
  endtask

  task automatic push_record(input rec_e kind, input logic [15:0] addr, input int unsigned len);
    logic [7:0] sum;
    logic [7:0] count;
    if (kind != REC_S0) begin
      push_char(CHAR_NL);
    end
    push_char(CHAR_S);
    case (kind)
      REC_S0:  push_char("0");
      REC_S1:  push_char("1");
      REC_S5:  push_char("5");
      default: push_char("9");
    endcase
    count = 8'(len + 3);
    sum = count + addr[15:8] + addr[7:0];
    push_hex(count);
    push_hex(addr[15:8]);
    push_hex(addr[7:0]);
    for (int i = 0; i < len; i++) begin
      push_hex(rec_bytes[i]);
      sum += rec_bytes[i];
    end
    push_hex(~sum);
  endtask

  task automatic open_stream();
    held_count = 0;
    s1_count = '0;
    rec_addr = load_addr;
  endtask

  task automatic flush_data_record();
    for (int i = 0; i < held_count; i++) begin
      rec_bytes[i] = held_bytes[i];
    end
    push_record(REC_S1, rec_addr, held_count);
    rec_addr += 16'(held_count);
    s1_count += 16'd1;
    held_count = 0;
  endtask

  task automatic encode_item(input logic [1:0] op, input logic [7:0] value);
    int unsigned       first;
    int unsigned       hdr_chars;
    logic [TEXT_W-1:0] word;
    first = expected_beats.size();
    case (op)
      OP_START: begin
        hdr_chars = (hdr_len > HDR_MAX) ? HDR_MAX : hdr_len;
        for (int i = 0; i < HDR_MAX; i++) begin
          word = (i < 8) ? hdr_hi : hdr_lo;
          rec_bytes[i] = word[8 * (7 - i % 8) +: 8];
        end
        open_stream();
        push_record(REC_S0, '0, hdr_chars);
      end
      OP_DATA: begin
        if (held_count < RECORD_DATA_BYTES_DEF) begin
          held_bytes[held_count] = value;
          held_count++;
        end
        if (held_count >= RECORD_DATA_BYTES_DEF) begin
          flush_data_record();
        end
      end
      OP_END: begin
        if (held_count > 0) begin
          flush_data_record();
        end
        push_record(REC_S5, s1_count, 0);
        push_record(REC_S9, '0, 0);
        open_stream();
      end
      default: begin
      end
    endcase
    if (expected_beats.size() > first) begin
      expected_beats[expected_beats.size() - 1].last = 1'b1;
    end
  endtask

  task automatic check_beat(input logic [7:0] ch, input logic last);
    srec_beat_t want;
    if (expected_beats.size() == 0) begin
      $display("%0t: unexpected beat, character %h last %b", $time, ch, last);
      mismatch_count++;
    end else begin
      want = expected_beats.pop_front();
      if (ch !== want.ch) begin
        $display("%0t: character expected %h, got %h", $time, want.ch, ch);
        mismatch_count++;
      end
      if (last !== want.last) begin
        $display("%0t: last_of_run expected %b, got %b", $time, want.last, last);
        mismatch_count++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_hi = '0;
      hdr_lo = '0;
      hdr_len = '0;
      load_addr = '0;
      open_stream();
      expected_beats.delete();
      chars_pending = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_HDR_HIGH:   hdr_hi = cfg_wdata_i;
          CFG_HDR_LOW:    hdr_lo = cfg_wdata_i;
          CFG_HDR_LENGTH: hdr_len = cfg_wdata_i[LEN_W-1:0];
          default:        load_addr = cfg_wdata_i[ADDR_W-1:0];
        endcase
      end
      if (out_valid_o && out_ready_i) begin
        check_beat(character_o, last_of_run_o);
      end
      if (in_valid_i && in_ready_o) begin
        encode_item(op_i, data_byte_i);
      end
      chars_pending = expected_beats.size();
    end
  end

endmodule

>>> test/tb_top.sv
// Testbench top for the S19 encoder: clock, reset, stimulus, receiver stalls and the verdict.
module tb_top import srec_pkg::*;;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int SETTLE_CYCLES       = 60;
  localparam int CYCLE_LIMIT         = 2_000_000;
  localparam int HOLD_AT_BEAT        = 800;
  localparam int HOLD_CYCLES         = 400;
  localparam int PHASES              = 6;
  localparam int PHASE_ITEMS         = 60;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [TEXT_W-1:0]    cfg_wdata_i = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  logic [1:0]           op_i        = '0;
  logic [7:0]           data_byte_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [7:0]           character_o;
  logic                 last_of_run_o;
  int                   mismatch_count;
  int                   chars_pending;

  int items_sent = 0;
  int cycle_count = 0;
  bit in_steady = 1'b0;

  s_record_stream_encoder_top dut (.*);

  srec_check u_check (.*);

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [7:0] value);
    int gap;
    gap = in_steady ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    op_i        <= op;
    data_byte_i <= value;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    if (op != OP_UNUSED) begin
      items_sent++;
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TEXT_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_config(input logic [TEXT_W-1:0] hi, input logic [TEXT_W-1:0] lo,
                             input logic [LEN_W-1:0] len, input logic [ADDR_W-1:0] addr);
    write_reg(CFG_HDR_HIGH, hi);
    write_reg(CFG_HDR_LOW, lo);
    write_reg(CFG_HDR_LENGTH, TEXT_W'(len));
    write_reg(CFG_START_ADDR, TEXT_W'(addr));
  endtask

  // Wait until every predicted character has been taken and the sequencer has gone quiet.
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (chars_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_streams(input int quota);
    int target;
    int count;
    target = items_sent + quota;
    while (items_sent < target) begin
      in_steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 7) != 0) begin
        send_item(OP_START, 8'($urandom_range(0, 255)));
        count = ($urandom_range(0, 3) == 0) ? $urandom_range(16, 48) : $urandom_range(0, 17);
        for (int i = 0; i < count; i++) begin
          if ($urandom_range(0, 24) == 0) begin
            send_item(OP_UNUSED, 8'($urandom_range(0, 255)));
          end
          send_item(OP_DATA, 8'($urandom_range(0, 255)));
        end
        send_item(OP_END, 8'($urandom_range(0, 255)));
      end else begin
        count = $urandom_range(1, 4);
        for (int i = 0; i < count; i++) begin
          send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        end
      end
    end
  endtask

  initial begin : receiver
    int gap;
    int beats;
    bit steady;
    beats = 0;
    steady = 1'b0;
    wait (rst_ni);
    forever begin
      if (beats % 50 == 0) begin
        steady = ($urandom_range(0, 3) == 0);
      end
      if (beats == HOLD_AT_BEAT) begin
        gap = HOLD_CYCLES;
      end else begin
        gap = steady ? 0 : $urandom_range(0, 14);
      end
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
      beats++;
    end
  end

  initial begin : stimulus
    logic [TEXT_W-1:0] hi;
    logic [TEXT_W-1:0] lo;
    logic [LEN_W-1:0]  len;
    logic [ADDR_W-1:0] addr;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Full header, a start address that wraps, data ahead of any start.
    load_config(64'h5331395F54455354, 64'h00FF80017F0A0D20, 5'd16, 16'hFFF8);
    send_item(OP_DATA, 8'hFF);
    send_item(OP_START, 8'h00);
    for (int i = 0; i < 16; i++) begin
      case (i % 4)
        0:       send_item(OP_DATA, 8'h00);
        1:       send_item(OP_DATA, 8'hFF);
        2:       send_item(OP_DATA, 8'hA5);
        default: send_item(OP_DATA, 8'h5A);
      endcase
    end
    send_item(OP_UNUSED, 8'hFF);
    send_item(OP_END, 8'h00);
    settle();

    // Empty header, partial record flushed at the end, address change while a stream is open,
    // and an over-long header length.
    load_config(64'h0123456789ABCDEF, 64'hFEDCBA9876543210, 5'd0, 16'h0000);
    send_item(OP_START, 8'h00);
    send_item(OP_DATA, 8'h01);
    send_item(OP_DATA, 8'h02);
    send_item(OP_DATA, 8'h03);
    settle();
    write_reg(CFG_START_ADDR, TEXT_W'(16'h1234));
    write_reg(CFG_HDR_LENGTH, TEXT_W'(5'd31));
    send_item(OP_DATA, 8'h04);
    send_item(OP_END, 8'h00);
    send_item(OP_START, 8'h00);
    settle();

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          hi = '1;
          lo = '1;
          len = 5'd16;
          addr = 16'hFFFF;
        end
        1: begin
          hi = '0;
          lo = '0;
          len = 5'd0;
          addr = 16'h0000;
        end
        2: begin
          hi = {$urandom, $urandom};
          lo = {$urandom, $urandom};
          len = LEN_W'($urandom_range(17, 31));
          addr = ADDR_W'($urandom_range(0, 65535));
        end
        default: begin
          hi = {$urandom, $urandom};
          lo = {$urandom, $urandom};
          len = LEN_W'($urandom_range(0, 31));
          addr = ADDR_W'($urandom_range(0, 65535));
        end
      endcase
      load_config(hi, lo, len, addr);
      run_streams(PHASE_ITEMS);
      settle();
    end

    @(negedge clk_i);
    if (mismatch_count == 0 && chars_pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/srec_pkg.sv
hdl/srec_ctrl.sv
hdl/srec_dp.sv
hdl/s_record_stream_encoder_top.sv
test/srec_check.sv
test/tb_top.sv
